FILE: rtl/core/pca_pkg.sv
// pca_pkg: shared types, constants and table builders for pixel_color_adjust
// depends on nothing; used by every module of the block
`default_nettype none

package pca_pkg;

  // pipeline layout: front end, log stages, exp stages
  localparam int FRONT_STG = 5;
  localparam int LOG_STG   = 17;
  localparam int EXP_STG   = 19;
  localparam int LOG_BASE  = FRONT_STG;
  localparam int EXP_BASE  = FRONT_STG + LOG_STG;
  localparam int TOTAL_STG = FRONT_STG + LOG_STG + EXP_STG;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // bt.601 luma weights in units of 1/65536
  localparam logic signed [16:0] LUMA_R = 17'sd19595;
  localparam logic signed [16:0] LUMA_G = 17'sd38470;
  localparam logic signed [16:0] LUMA_B = 17'sd7471;

  // 1.0 in q30
  localparam logic [30:0] R_ONE = 31'h4000_0000;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_CONTRAST   = 2'd1,
    CFG_SATURATION = 2'd2,
    CFG_INV_GAMMA  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [9:0] brightness_offset;
    logic [9:0]        contrast_gain;
    logic [9:0]        saturation_gain;
    logic [15:0]       inverse_gamma;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  // channel after saturation: not-positive flag and value clamped to 1..65536
  typedef struct packed {
    logic        neg;
    logic [16:0] xc;
  } lvl_t;

  // channel after log: exponent of the top bit and fraction bits of log2 of the mantissa
  typedef struct packed {
    logic        neg;
    logic [4:0]  e;
    logic [15:0] frac;
  } lg_t;

  typedef logic [15:0][29:0] exp_tab_t;

  // integer square root, evaluated at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = v;
    res   = '0;
    bit_w = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (bit_w > rem) bit_w = bit_w >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bit_w != 64'd0) begin
        if (rem >= res + bit_w) begin
          rem = rem - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // q30 values of 2^(-2^-i) for i = 1..16 by repeated square roots of one half
  function automatic exp_tab_t build_exp_tab();
    logic [63:0] h;
    exp_tab_t    tab;
    h = 64'd1 << 29;
    for (int j = 0; j < 16; j++) begin
      h      = isqrt64(h << 30);
      tab[j] = h[29:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

FILE: rtl/core/pca_front.sv
// pca_front: normalize, brightness, contrast, luma and saturation for one pixel
// depends on pca_pkg; five register stages, each loaded by its own enable
`default_nettype none

module pca_front (
  input  wire logic                               clk,
  input  wire logic [pca_pkg::FRONT_STG-1:0]      ld,
  input  wire pca_pkg::pix_in_t                   pix,
  input  wire pca_pkg::cfg_t                      cfg,
  output pca_pkg::lvl_t [2:0]                     lvl
);

  logic [7:0]         ch_in [3];

  // stage registers
  logic signed [18:0] d_r    [3];
  logic signed [20:0] x2_r   [3];
  logic signed [20:0] x2b_r  [3];
  logic signed [37:0] lp_r   [3];
  logic signed [20:0] gray_r;
  logic signed [21:0] diff_r [3];
  pca_pkg::lvl_t      lvl_r  [3];

  // next values
  logic signed [18:0] d_nxt    [3];
  logic signed [20:0] x2_nxt   [3];
  logic signed [37:0] lp_nxt   [3];
  logic signed [20:0] gray_nxt;
  logic signed [21:0] diff_nxt [3];
  pca_pkg::lvl_t      lvl_nxt  [3];

  logic signed [10:0] k_s;
  logic signed [10:0] s_s;
  logic signed [18:0] bsh;
  logic signed [16:0] luma [3];

  assign ch_in[0] = pix.red_in;
  assign ch_in[1] = pix.green_in;
  assign ch_in[2] = pix.blue_in;
  assign luma[0]  = pca_pkg::LUMA_R;
  assign luma[1]  = pca_pkg::LUMA_G;
  assign luma[2]  = pca_pkg::LUMA_B;
  assign k_s      = signed'({1'b0, cfg.contrast_gain});
  assign s_s      = signed'({1'b0, cfg.saturation_gain});
  assign bsh      = signed'({cfg.brightness_offset[9], cfg.brightness_offset, 8'h00});

  // stage 0: c*65536/255 is c*257 plus one at full scale, then brightness, minus one half
  always_comb begin
    logic [16:0]        x0;
    logic signed [18:0] x1;
    for (int c = 0; c < 3; c++) begin
      x0       = {1'b0, ch_in[c], ch_in[c]} + {16'h0000, (ch_in[c] == 8'hFF)};
      x1       = signed'({2'b00, x0}) + bsh;
      d_nxt[c] = x1 - 19'sd32768;
    end
  end

  // stage 1: contrast gain about one half
  always_comb begin
    logic signed [29:0] cprod;
    for (int c = 0; c < 3; c++) begin
      cprod     = d_r[c] * k_s;
      x2_nxt[c] = signed'(cprod[28:8]) + 21'sd32768;
    end
  end

  // stage 2: luma weighted products
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      lp_nxt[c] = x2_r[c] * luma[c];
    end
  end

  // stage 3: luma sum and distance of each channel from it
  always_comb begin
    logic signed [37:0] sum;
    sum      = lp_r[0] + lp_r[1] + lp_r[2];
    gray_nxt = signed'(sum[36:16]);
    for (int c = 0; c < 3; c++) begin
      diff_nxt[c] = signed'({x2b_r[c][20], x2b_r[c]}) - signed'({gray_nxt[20], gray_nxt});
    end
  end

  // stage 4: saturation mix and clamp to the log input range
  always_comb begin
    logic signed [32:0] sp;
    logic signed [25:0] x3;
    logic               big;
    for (int c = 0; c < 3; c++) begin
      sp  = diff_r[c] * s_s;
      x3  = signed'({{5{gray_r[20]}}, gray_r}) + signed'({sp[32], sp[32:8]});
      big = !x3[25] && (x3[24:16] != 9'd0);
      lvl_nxt[c].neg = x3[25] || (x3 == 26'sd0);
      lvl_nxt[c].xc  = big ? 17'h10000 : {1'b0, x3[15:0]};
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (ld[0]) d_r[c] <= d_nxt[c];
      if (ld[1]) x2_r[c] <= x2_nxt[c];
      if (ld[2]) begin
        lp_r[c]  <= lp_nxt[c];
        x2b_r[c] <= x2_r[c];
      end
      if (ld[3]) diff_r[c] <= diff_nxt[c];
      if (ld[4]) lvl_r[c] <= lvl_nxt[c];
    end
    if (ld[3]) gray_r <= gray_nxt;
  end

  assign lvl[0] = lvl_r[0];
  assign lvl[1] = lvl_r[1];
  assign lvl[2] = lvl_r[2];

endmodule

`default_nettype wire

FILE: rtl/core/pca_log.sv
// pca_log: log2 of one channel as exponent and q16 fraction by sixteen squarings of a q30 mantissa
// depends on pca_pkg; one normalize stage then one squaring per stage
`default_nettype none

module pca_log (
  input  wire logic                          clk,
  input  wire logic [pca_pkg::LOG_STG-1:0]   ld,
  input  wire pca_pkg::lvl_t                 lvl,
  output pca_pkg::lg_t                       lg
);

  localparam int NSQ = pca_pkg::LOG_STG - 1;

  logic [30:0] m_r    [NSQ];
  logic [4:0]  e_r    [pca_pkg::LOG_STG];
  logic        neg_r  [pca_pkg::LOG_STG];
  logic [15:0] frac_r [pca_pkg::LOG_STG];

  logic [30:0] m0_nxt;
  logic [4:0]  e0_nxt;
  logic [31:0] sq_top [1:NSQ];
  logic [30:0] m_nxt  [1:NSQ-1];
  logic [15:0] frac_nxt [1:NSQ];

  // stage 0: top bit position and mantissa in [1, 2) as q30
  always_comb begin
    e0_nxt = '0;
    for (int b = 0; b < 17; b++) begin
      if (lvl.xc[b]) e0_nxt = 5'(b);
    end
    m0_nxt = {14'h0000, lvl.xc} << (5'd30 - e0_nxt);
  end

  // squaring stages: a mantissa at or above two gives a fraction bit
  always_comb begin
    logic [61:0] sq;
    for (int j = 1; j <= NSQ; j++) begin
      sq          = m_r[j-1] * m_r[j-1];
      sq_top[j]   = sq[61:30];
      frac_nxt[j] = frac_r[j-1] | ({15'h0000, sq_top[j][31]} << (NSQ - j));
    end
    for (int j = 1; j < NSQ; j++) begin
      m_nxt[j] = sq_top[j][31] ? sq_top[j][31:1] : sq_top[j][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      m_r[0]    <= m0_nxt;
      e_r[0]    <= e0_nxt;
      neg_r[0]  <= lvl.neg;
      frac_r[0] <= '0;
    end
    for (int j = 1; j <= NSQ; j++) begin
      if (ld[j]) begin
        e_r[j]    <= e_r[j-1];
        neg_r[j]  <= neg_r[j-1];
        frac_r[j] <= frac_nxt[j];
      end
    end
    for (int j = 1; j < NSQ; j++) begin
      if (ld[j]) m_r[j] <= m_nxt[j];
    end
  end

  assign lg.neg  = neg_r[NSQ];
  assign lg.e    = e_r[NSQ];
  assign lg.frac = frac_r[NSQ];

endmodule

`default_nettype wire

FILE: rtl/core/pca_exp.sv
// pca_exp: gamma exponent, 2^-t in q30 and final scale by 255 for one channel
// depends on pca_pkg (EXP_TAB of root-of-two factors); at most one multiply per stage
`default_nettype none

module pca_exp (
  input  wire logic                          clk,
  input  wire logic [pca_pkg::EXP_STG-1:0]   ld,
  input  wire pca_pkg::lg_t                  lg,
  input  wire logic [15:0]                   inverse_gamma,
  output logic [7:0]                         val
);

  localparam int LAST = pca_pkg::EXP_STG - 1;  // output stage
  localparam int RLST = LAST - 1;              // last multiply stage

  logic [20:0] l_r;
  logic        neg_r [RLST+1];
  logic [4:0]  sh_r  [1:RLST];
  logic        big_r [1:RLST];
  logic [15:0] tf_r  [1:RLST-1];
  logic [30:0] r_r   [2:RLST];
  logic [7:0]  val_r;

  logic [20:0] l_nxt;
  logic [24:0] t_nxt;
  logic        big_nxt;
  logic [30:0] r_nxt [2:RLST];
  logic [7:0]  val_nxt;

  // stage 0: integer part minus fraction gives -log2 in q16
  assign l_nxt = {5'd16 - lg.e, 16'h0000} - {5'b00000, lg.frac};

  // stage 1: scale by the inverse gamma
  always_comb begin
    logic [36:0] lprod;
    lprod   = l_r * inverse_gamma;
    t_nxt   = lprod[36:12];
    big_nxt = (t_nxt[24:21] != 4'h0) || (t_nxt[20:16] == 5'd31);
  end

  // multiply stages: one root-of-two factor per fraction bit, msb first
  always_comb begin
    logic [60:0] prod;
    r_nxt[2] = tf_r[1][15] ? {1'b0, pca_pkg::EXP_TAB[0]} : pca_pkg::R_ONE;
    for (int s = 3; s <= RLST; s++) begin
      prod     = r_r[s-1] * pca_pkg::EXP_TAB[s-2];
      r_nxt[s] = tf_r[s-1][RLST-s] ? prod[60:30] : r_r[s-1];
    end
  end

  // output stage: integer shift, times 255, not-positive channels forced
  always_comb begin
    logic [30:0] rs;
    logic [38:0] o39;
    rs  = big_r[RLST] ? 31'h0 : (r_r[RLST] >> sh_r[RLST]);
    o39 = {rs, 8'h00} - {8'h00, rs};
    if (neg_r[RLST]) begin
      val_nxt = (inverse_gamma == 16'h0000) ? 8'hFF : 8'h00;
    end else begin
      val_nxt = o39[37:30];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      l_r      <= l_nxt;
      neg_r[0] <= lg.neg;
    end
    if (ld[1]) begin
      neg_r[1] <= neg_r[0];
      sh_r[1]  <= t_nxt[20:16];
      big_r[1] <= big_nxt;
      tf_r[1]  <= t_nxt[15:0];
    end
    for (int s = 2; s <= RLST; s++) begin
      if (ld[s]) begin
        neg_r[s] <= neg_r[s-1];
        sh_r[s]  <= sh_r[s-1];
        big_r[s] <= big_r[s-1];
        r_r[s]   <= r_nxt[s];
      end
    end
    for (int s = 2; s < RLST; s++) begin
      if (ld[s]) tf_r[s] <= tf_r[s-1];
    end
    if (ld[LAST]) val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

`default_nettype wire

FILE: rtl/core/pixel_color_adjust.sv
// pixel_color_adjust: brightness, contrast, saturation and gamma on rgb pixels
// depends on pca_pkg, pca_front, pca_log, pca_exp
//
//   channel  ports                          handshake
//   input    in_valid in_ready in_data      valid/ready, pca_pkg::pix_in_t
//   output   out_valid out_ready out_data   valid/ready, pca_pkg::pix_out_t
//   config   cfg_we cfg_addr cfg_wdata      write on cfg_we, no wait
//
// one pixel per clock sustained while out_ready stays high; a pixel goes through 41
// register stages, among them the log's 16 squarings and the exp's 16 multiply stages. each
// stage holds a valid bit and loads when out_ready is high or when it or any stage after
// it is empty, so bubbles close up while the output waits and nothing is lost or repeated.
// rst_n (synchronous) clears the valid bits and sets the configuration registers to their defaults.
`default_nettype none

module pixel_color_adjust (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire pca_pkg::pix_in_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output pca_pkg::pix_out_t                        out_data,
  input  wire logic                                cfg_we,
  input  wire logic [pca_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [pca_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int N = pca_pkg::TOTAL_STG;

  pca_pkg::cfg_t       cfg_r;
  logic [N-1:0]        vld_r;
  logic [N-1:0]        ld;
  pca_pkg::lvl_t [2:0] lvl;
  pca_pkg::lg_t        lg  [3];
  logic [7:0]          val [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness_offset <= 10'sd0;
      cfg_r.contrast_gain     <= 10'd256;
      cfg_r.saturation_gain   <= 10'd256;
      cfg_r.inverse_gamma     <= 16'd4096;
    end else if (cfg_we) begin
      unique case (pca_pkg::cfg_idx_t'(cfg_addr))
        pca_pkg::CFG_BRIGHTNESS: cfg_r.brightness_offset <= signed'(cfg_wdata[9:0]);
        pca_pkg::CFG_CONTRAST:   cfg_r.contrast_gain     <= cfg_wdata[9:0];
        pca_pkg::CFG_SATURATION: cfg_r.saturation_gain   <= cfg_wdata[9:0];
        pca_pkg::CFG_INV_GAMMA:  cfg_r.inverse_gamma     <= cfg_wdata;
        default:                 cfg_r                   <= cfg_r;
      endcase
    end
  end

  // stage load enables: free on out_ready or if any stage from here to the output is empty
  for (genvar s = 0; s < N; s++) begin : g_ld
    assign ld[s] = out_ready || !(&vld_r[N-1:s]);
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_valid;
      for (int s = 1; s < N; s++) begin
        if (ld[s]) vld_r[s] <= vld_r[s-1];
      end
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld_r[N-1];

  pca_front u_front (
    .clk (clk),
    .ld  (ld[pca_pkg::FRONT_STG-1:0]),
    .pix (in_data),
    .cfg (cfg_r),
    .lvl (lvl)
  );

  for (genvar c = 0; c < 3; c++) begin : g_ch
    pca_log u_log (
      .clk (clk),
      .ld  (ld[pca_pkg::EXP_BASE-1:pca_pkg::LOG_BASE]),
      .lvl (lvl[c]),
      .lg  (lg[c])
    );

    pca_exp u_exp (
      .clk           (clk),
      .ld            (ld[N-1:pca_pkg::EXP_BASE]),
      .lg            (lg[c]),
      .inverse_gamma (cfg_r.inverse_gamma),
      .val           (val[c])
    );
  end

  assign out_data.red_out   = val[0];
  assign out_data.green_out = val[1];
  assign out_data.blue_out  = val[2];

endmodule

`default_nettype wire

FILE: rtl/core/pca_checker.sv
// pca_checker: port-level checks on pixel_color_adjust, attached by bind
// depends on pca_pkg and the top level port list
`default_nettype none

module pca_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_ready,
  input wire pca_pkg::pix_in_t                 in_data,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire pca_pkg::pix_out_t                out_data,
  input wire logic                             cfg_we,
  input wire logic [pca_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input wire logic [pca_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty output stage leaves room for a new transaction
  a_room_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // a draining output lets the whole pipeline advance
  a_room_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind pixel_color_adjust pca_checker u_pca_checker (.*);

`default_nettype wire
